>>> design/frd_pkg.sv
// Shared types and constants for the fraction reducer.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package frd_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_WIDTH - 1);

   typedef logic [DATA_WIDTH-1:0] mag_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // item accepted: capture magnitudes and signs
      logic strip;      // drop a common factor of two
      logic gcd_step;   // one binary GCD step
      logic div_start;  // start a division by the odd GCD
      logic div_sel_d;  // dividend is the denominator
      logic take_rn;    // store numerator quotient
      logic out_load;   // write the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic any_zero;
      logic both_even;
      logic gcd_equal;
      logic div_done;
      logic out_free;
   } sts_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STRIP = 6'b000010,
      ST_GCD   = 6'b000100,
      ST_DIVN  = 6'b001000,
      ST_DIVD  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

>>> design/frd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on frd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frd_div (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire frd_pkg::mag_type dividend,
   input  wire frd_pkg::mag_type divisor,
   output logic                 done,
   output frd_pkg::mag_type     quotient
);
   import frd_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   mag_type           rem_ff, rem_in;
   mag_type           quo_ff, quo_in;
   logic [DATA_WIDTH:0] trial, diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> design/frd_dpath.sv
// Datapath: magnitudes, binary GCD registers, divider and result register.
// Depends on frd_pkg and frd_div.
`timescale 1ns / 1ps
`default_nettype none

module frd_dpath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire frd_pkg::cmd_type          cmd,
   output frd_pkg::sts_type               sts,
   input  wire logic signed [frd_pkg::DATA_WIDTH-1:0] req_numerator,
   input  wire logic signed [frd_pkg::DATA_WIDTH-1:0] req_denominator,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [frd_pkg::DATA_WIDTH-1:0] rsp_reduced_num,
   output logic [frd_pkg::DATA_WIDTH-2:0] rsp_reduced_den,
   output logic                           rsp_is_whole,
   output logic                           rsp_status
);
   import frd_pkg::*;

   mag_type a_ff, a_in, b_ff, b_in;
   mag_type n_ff, n_in, d_ff, d_in;
   mag_type rn_ff;
   logic    neg_ff;
   mag_type a_minus_b, b_minus_a, quo;
   logic    div_done;

   logic                          valid_ff, valid_in;
   logic signed [DATA_WIDTH-1:0]  num_ff, num_in;
   logic [DATA_WIDTH-2:0]         den_ff, den_in;
   logic                          whole_ff, whole_in;
   logic                          stat_ff, stat_in;

   frd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel_d ? d_ff : n_ff),
      .divisor  (a_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;

   // GCD registers; negation of the most negative value yields 2^(W-1), as wanted
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      n_in = n_ff;
      d_in = d_ff;
      if (cmd.load) begin
         a_in = req_numerator[DATA_WIDTH-1] ? mag_type'(-req_numerator)
                                            : mag_type'(req_numerator);
         b_in = req_denominator[DATA_WIDTH-1] ? mag_type'(-req_denominator)
                                              : mag_type'(req_denominator);
         n_in = a_in;
         d_in = b_in;
      end else if (cmd.strip) begin
         a_in = a_ff >> 1;
         b_in = b_ff >> 1;
         n_in = n_ff >> 1;
         d_in = d_ff >> 1;
      end else if (cmd.gcd_step) begin
         if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = a_minus_b >> 1;
         end else begin
            b_in = b_minus_a >> 1;
         end
      end
   end

   // result formatting
   always_comb begin
      valid_in = valid_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      whole_in = whole_ff;
      stat_in  = stat_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         valid_in = 1'b1;
         if (d_ff == '0) begin
            num_in   = '0;
            den_in   = '0;
            whole_in = 1'b0;
            stat_in  = 1'b1;
         end else if (n_ff == '0) begin
            num_in   = '0;
            den_in   = (DATA_WIDTH-1)'(1);
            whole_in = 1'b1;
            stat_in  = 1'b0;
         end else begin
            if (neg_ff) begin
               num_in = -$signed(rn_ff);
            end else if (rn_ff[DATA_WIDTH-1]) begin
               num_in = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end else begin
               num_in = $signed(rn_ff);
            end
            den_in   = quo[DATA_WIDTH-1] ? {(DATA_WIDTH-1){1'b1}} : quo[DATA_WIDTH-2:0];
            whole_in = (quo == mag_type'(1));
            stat_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      whole_ff <= whole_in;
      stat_ff  <= stat_in;
      if (cmd.load) begin
         neg_ff <= req_numerator[DATA_WIDTH-1] ^ req_denominator[DATA_WIDTH-1];
      end
      if (cmd.take_rn) begin
         rn_ff <= quo;
      end
   end

   assign sts.any_zero  = (a_ff == '0) || (b_ff == '0);
   assign sts.both_even = !a_ff[0] && !b_ff[0];
   assign sts.gcd_equal = (a_ff == b_ff);
   assign sts.div_done  = div_done;
   assign sts.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid       = valid_ff;
   assign rsp_reduced_num = num_ff;
   assign rsp_reduced_den = den_ff;
   assign rsp_is_whole    = whole_ff;
   assign rsp_status      = stat_ff;

endmodule

`default_nettype wire

>>> design/frd_ctrl.sv
// Sequencer for the fraction reducer: strip, GCD, two divisions, write-out.
// Depends on frd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire frd_pkg::sts_type sts,
   output frd_pkg::cmd_type      cmd
);
   import frd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (sts.any_zero) begin
               state_in = ST_DONE;
            end else if (sts.both_even) begin
               cmd.strip = 1'b1;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_equal) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIVN: begin
            if (sts.div_done) begin
               cmd.take_rn   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel_d = 1'b1;
               state_in      = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (sts.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

>>> design/fraction_reducer_core.sv
// Fraction reducer: signed a/b to lowest terms, sign on the numerator.
// Steps: load, strip common factors of two, binary GCD, numerator and denominator
//   divides by the GCD, then write-out. A zero numerator or denominator goes from
//   strip straight to write-out. One item in flight; a finished result
//   may wait in the output register while the next item is accepted.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module fraction_reducer_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [frd_pkg::DATA_WIDTH-1:0] req_numerator,
   input  wire logic signed [frd_pkg::DATA_WIDTH-1:0] req_denominator,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [frd_pkg::DATA_WIDTH-1:0] rsp_reduced_num,
   output logic [frd_pkg::DATA_WIDTH-2:0] rsp_reduced_den,
   output logic                           rsp_is_whole,
   output logic                           rsp_status
);
   import frd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: idle -> strip common twos -> binary GCD -> numerator divide
   //   -> denominator divide -> write result when output register is free.
   frd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: both operands and their copies are shifted together while both
   // are even, so after the odd GCD is found the copies divide exactly by it.
   frd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reduced_num (rsp_reduced_num),
      .rsp_reduced_den (rsp_reduced_den),
      .rsp_is_whole    (rsp_is_whole),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire
